// ----- design/abs_pkg.sv -----
// Package for the alternating-bit sender: sizes, operation codes, state
// encodings and the control structs passed between the sender's modules.
// No dependencies; every other design file but abs_ram imports it.
package abs_pkg;

  localparam int PAYLOAD_BYTES = 20;
  localparam int CNT_W         = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int BYTE_W        = 8;
  localparam int WORD_W        = 32;
  localparam int SUM_W         = 13;
  localparam int TIMER_W       = 16;

  localparam logic [CNT_W-1:0]   LAST_IDX      = CNT_W'(PAYLOAD_BYTES - 1);
  localparam logic [TIMER_W-1:0] TIMEOUT_RESET = TIMER_W'(1000);

  typedef enum logic [1:0] {
    OP_MSG  = 2'd0,
    OP_ACK  = 2'd1,
    OP_TICK = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUILD,
    ST_EMIT,
    ST_ACK_SEQ,
    ST_ACK_CHK
  } seq_state_e;

  typedef enum logic {
    EM_IDLE,
    EM_SHOW
  } em_state_e;

  typedef enum logic [2:0] {
    ALU_MSG,
    ALU_ACK,
    ALU_TICK,
    ALU_CK,
    ALU_SEQ,
    ALU_HACK
  } alu_sel_e;

  typedef struct packed {
    logic [SUM_W-1:0]   msg_sum;
    logic [WORD_W-1:0]  ack_sum;
    logic [TIMER_W-1:0] timer;
    logic [BYTE_W-1:0]  data_byte;
    logic               alt;
    logic [WORD_W-1:0]  hdr_seq;
    logic [WORD_W-1:0]  hdr_ack;
    logic [WORD_W-1:0]  hdr_ck;
  } alu_opnd_t;

  typedef struct packed {
    logic             start;
    logic             resend;
    logic             seq;
    logic [SUM_W-1:0] checksum;
  } emit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } emit_sts_t;

endpackage

// ----- design/abs_in_if.sv -----
// Input channel of the alternating-bit sender: message bytes, ack bytes
// with the ack header, and timer ticks. Depends on abs_pkg.
interface abs_in_if;
  import abs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               op;
  logic signed [BYTE_W-1:0] data_byte;
  logic signed [WORD_W-1:0] in_seqnum;
  logic signed [WORD_W-1:0] in_acknum;
  logic signed [WORD_W-1:0] in_checksum;

  modport source (output valid, op, data_byte, in_seqnum, in_acknum, in_checksum,
                  input ready);
  modport sink (input valid, op, data_byte, in_seqnum, in_acknum, in_checksum,
                output ready);
endinterface

// ----- design/abs_out_if.sv -----
// Output channel of the alternating-bit sender: one beat per payload byte
// of a sent packet with its header fields. Depends on abs_pkg.
interface abs_out_if;
  import abs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     out_seqnum;
  logic                     out_acknum;
  logic signed [SUM_W-1:0]  out_checksum;
  logic signed [BYTE_W-1:0] out_byte;
  logic                     last;
  logic                     resend;

  modport source (output valid, out_seqnum, out_acknum, out_checksum, out_byte, last,
                  resend, input ready);
  modport sink (input valid, out_seqnum, out_acknum, out_checksum, out_byte, last,
                resend, output ready);
endinterface

// ----- design/abs_ram.sv -----
// Generic RAM: one write port and one read port with registered read data.
// No dependencies.
module abs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 20
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- design/abs_alu.sv -----
// Shared 32-bit adder and equality compare of the sender, with its
// operand selection. Depends on abs_pkg.
module abs_alu (
  input  abs_pkg::alu_sel_e             sel_i,
  input  abs_pkg::alu_opnd_t            opnd_i,
  output logic [abs_pkg::WORD_W-1:0]    sum_o,
  output logic                          eq_o
);
  import abs_pkg::*;

  logic [WORD_W-1:0] a;
  logic [WORD_W-1:0] b;
  logic [WORD_W-1:0] byte_ext;

  assign byte_ext = {{(WORD_W - BYTE_W){opnd_i.data_byte[BYTE_W-1]}}, opnd_i.data_byte};

  always_comb begin
    case (sel_i)
      ALU_MSG: begin
        a = {{(WORD_W - SUM_W){1'b0}}, opnd_i.msg_sum};
        b = byte_ext;
      end
      ALU_ACK: begin
        a = opnd_i.ack_sum;
        b = byte_ext;
      end
      ALU_TICK: begin
        a = {{(WORD_W - TIMER_W){1'b0}}, opnd_i.timer};
        b = '1;
      end
      ALU_CK: begin
        a = {{(WORD_W - SUM_W){1'b0}}, opnd_i.msg_sum};
        b = {{(WORD_W - 1){1'b0}}, opnd_i.alt};
      end
      ALU_SEQ: begin
        a = opnd_i.ack_sum;
        b = opnd_i.hdr_seq;
      end
      ALU_HACK: begin
        a = opnd_i.ack_sum;
        b = opnd_i.hdr_ack;
      end
      default: begin
        a = '0;
        b = '0;
      end
    endcase
  end

  assign sum_o = a + b;
  assign eq_o  = (sum_o == opnd_i.hdr_ck);

endmodule

// ----- design/abs_emit.sv -----
// Packet readout of the sender: walks the packet store through its
// registered read port and presents one output beat per payload byte.
// Depends on abs_pkg and abs_out_if.
module abs_emit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  abs_pkg::emit_ctl_t         ctl_i,
  output abs_pkg::emit_sts_t         sts_o,
  output logic                       re_o,
  output logic [abs_pkg::CNT_W-1:0]  raddr_o,
  input  logic [abs_pkg::BYTE_W-1:0] rdata_i,
  abs_out_if.source                  out_ch
);
  import abs_pkg::*;

  em_state_e        state_q, state_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             seq_q, resend_q;
  logic [SUM_W-1:0] ck_q;
  logic             is_last;
  logic             beat;

  assign is_last = (idx_q == LAST_IDX);
  assign beat    = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EM_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start && state_q == EM_IDLE) begin
      seq_q    <= ctl_i.seq;
      resend_q <= ctl_i.resend;
      ck_q     <= ctl_i.checksum;
    end
  end

  // The read data register only moves on a read, so a stalled beat holds.
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    re_o         = 1'b0;
    raddr_o      = idx_q;
    sts_o.done   = 1'b0;
    sts_o.busy   = (state_q == EM_SHOW);
    case (state_q)
      EM_IDLE: begin
        if (ctl_i.start) begin
          re_o    = 1'b1;
          raddr_o = '0;
          idx_d   = '0;
          state_d = EM_SHOW;
        end
      end
      EM_SHOW: begin
        if (beat) begin
          if (is_last) begin
            sts_o.done = 1'b1;
            state_d    = EM_IDLE;
          end else begin
            re_o    = 1'b1;
            raddr_o = idx_q + CNT_W'(1);
            idx_d   = idx_q + CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = EM_IDLE;
      end
    endcase
  end

  assign out_ch.valid        = (state_q == EM_SHOW);
  assign out_ch.out_seqnum   = seq_q;
  assign out_ch.out_acknum   = 1'b0;
  assign out_ch.out_checksum = ck_q;
  assign out_ch.out_byte     = rdata_i;
  assign out_ch.last         = is_last;
  assign out_ch.resend       = resend_q;

endmodule

// ----- design/alternating_bit_sender.sv -----
// Alternating-bit (stop-and-wait) sender. The final ack byte is followed
// by the header check, which runs through the one shared 32-bit adder in
// two further steps. The final byte of a message that is sent is followed
// by a step that forms the checksum on the same adder, then PAYLOAD_BYTES
// output beats (20 at one per cycle when the sink is ready) read from the
// packet store's registered port; input is taken again in the cycle after
// the last beat. A timeout retransmission is the tick plus the same beats.
// Input is not taken while a packet is being sent.
// Depends on abs_pkg, abs_in_if, abs_out_if, abs_ram, abs_alu and abs_emit.
module alternating_bit_sender (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [abs_pkg::TIMER_W-1:0] cfg_wdata_i,
  abs_in_if.sink                      in_ch,
  abs_out_if.source                   out_ch
);
  import abs_pkg::*;

  seq_state_e         state_q, state_d;
  logic [TIMER_W-1:0] timeout_q;
  logic               alt_q, alt_d;
  logic               awaiting_q, awaiting_d;
  logic [SUM_W-1:0]   sent_ck_q, sent_ck_d;
  logic [CNT_W-1:0]   msg_cnt_q, msg_cnt_d;
  logic               discard_q, discard_d;
  logic [SUM_W-1:0]   msg_sum_q, msg_sum_d;
  logic [CNT_W-1:0]   ack_cnt_q, ack_cnt_d;
  logic [WORD_W-1:0]  ack_sum_q, ack_sum_d;
  logic [TIMER_W-1:0] timer_q, timer_d;
  logic [WORD_W-1:0]  hdr_seq_q, hdr_ack_q, hdr_ck_q;
  logic               hdr_ld;

  logic               accept;
  logic               discard_eff;
  logic [TIMER_W-1:0] load_val;

  alu_sel_e           alu_sel;
  alu_opnd_t          alu_opnd;
  logic [WORD_W-1:0]  alu_sum;
  logic               alu_eq;

  emit_ctl_t          emit_ctl;
  emit_sts_t          emit_sts;

  logic               ram_we;
  logic               ram_re;
  logic [CNT_W-1:0]   ram_raddr;
  logic [BYTE_W-1:0]  ram_rdata;

  assign in_ch.ready = (state_q == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign discard_eff = (msg_cnt_q == '0) ? awaiting_q : discard_q;
  assign load_val    = (timeout_q == '0) ? TIMER_W'(1) : timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      timeout_q  <= TIMEOUT_RESET;
      alt_q      <= 1'b1;
      awaiting_q <= 1'b0;
      sent_ck_q  <= '0;
      msg_cnt_q  <= '0;
      discard_q  <= 1'b0;
      msg_sum_q  <= '0;
      ack_cnt_q  <= '0;
      ack_sum_q  <= '0;
      timer_q    <= '0;
    end else begin
      state_q    <= state_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      alt_q      <= alt_d;
      awaiting_q <= awaiting_d;
      sent_ck_q  <= sent_ck_d;
      msg_cnt_q  <= msg_cnt_d;
      discard_q  <= discard_d;
      msg_sum_q  <= msg_sum_d;
      ack_cnt_q  <= ack_cnt_d;
      ack_sum_q  <= ack_sum_d;
      timer_q    <= timer_d;
    end
  end

  // The ack header is only meaningful on the final ack byte.
  always_ff @(posedge clk_i) begin
    if (hdr_ld) begin
      hdr_seq_q <= in_ch.in_seqnum;
      hdr_ack_q <= in_ch.in_acknum;
      hdr_ck_q  <= in_ch.in_checksum;
    end
  end

  always_comb begin
    state_d           = state_q;
    alt_d             = alt_q;
    awaiting_d        = awaiting_q;
    sent_ck_d         = sent_ck_q;
    msg_cnt_d         = msg_cnt_q;
    discard_d         = discard_q;
    msg_sum_d         = msg_sum_q;
    ack_cnt_d         = ack_cnt_q;
    ack_sum_d         = ack_sum_q;
    timer_d           = timer_q;
    hdr_ld            = 1'b0;
    ram_we            = 1'b0;
    alu_sel           = ALU_MSG;
    emit_ctl.start    = 1'b0;
    emit_ctl.resend   = 1'b0;
    emit_ctl.seq      = alt_q;
    emit_ctl.checksum = sent_ck_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_ch.op)
            OP_MSG: begin
              alu_sel = ALU_MSG;
              ram_we  = !discard_eff;
              if (msg_cnt_q == LAST_IDX) begin
                msg_cnt_d = '0;
                discard_d = 1'b0;
                if (discard_eff) begin
                  msg_sum_d = '0;
                end else begin
                  msg_sum_d  = alu_sum[SUM_W-1:0];
                  alt_d      = !alt_q;
                  awaiting_d = 1'b1;
                  timer_d    = load_val;
                  state_d    = ST_BUILD;
                end
              end else begin
                msg_cnt_d = msg_cnt_q + CNT_W'(1);
                discard_d = discard_eff;
                msg_sum_d = alu_sum[SUM_W-1:0];
              end
            end
            OP_ACK: begin
              alu_sel   = ALU_ACK;
              ack_sum_d = alu_sum;
              if (ack_cnt_q == LAST_IDX) begin
                ack_cnt_d = '0;
                hdr_ld    = 1'b1;
                state_d   = ST_ACK_SEQ;
              end else begin
                ack_cnt_d = ack_cnt_q + CNT_W'(1);
              end
            end
            OP_TICK: begin
              alu_sel = ALU_TICK;
              if (awaiting_q) begin
                if (timer_q[TIMER_W-1:1] == '0) begin
                  timer_d         = load_val;
                  emit_ctl.start  = 1'b1;
                  emit_ctl.resend = 1'b1;
                  state_d         = ST_EMIT;
                end else begin
                  timer_d = alu_sum[TIMER_W-1:0];
                end
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_BUILD: begin
        // The sequence bit was flipped on the final byte; add it in now.
        alu_sel           = ALU_CK;
        sent_ck_d         = alu_sum[SUM_W-1:0];
        msg_sum_d         = '0;
        emit_ctl.start    = 1'b1;
        emit_ctl.checksum = alu_sum[SUM_W-1:0];
        state_d           = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_sts.done) begin
          state_d = ST_IDLE;
        end
      end
      ST_ACK_SEQ: begin
        alu_sel   = ALU_SEQ;
        ack_sum_d = alu_sum;
        state_d   = ST_ACK_CHK;
      end
      ST_ACK_CHK: begin
        alu_sel = ALU_HACK;
        if (alu_eq && hdr_ack_q == {{(WORD_W - 1){1'b0}}, alt_q}) begin
          timer_d    = '0;
          awaiting_d = 1'b0;
        end
        ack_sum_d = '0;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign alu_opnd.msg_sum   = msg_sum_q;
  assign alu_opnd.ack_sum   = ack_sum_q;
  assign alu_opnd.timer     = timer_q;
  assign alu_opnd.data_byte = in_ch.data_byte;
  assign alu_opnd.alt       = alt_q;
  assign alu_opnd.hdr_seq   = hdr_seq_q;
  assign alu_opnd.hdr_ack   = hdr_ack_q;
  assign alu_opnd.hdr_ck    = hdr_ck_q;

  abs_alu u_alu (
    .sel_i  (alu_sel),
    .opnd_i (alu_opnd),
    .sum_o  (alu_sum),
    .eq_o   (alu_eq)
  );

  abs_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PAYLOAD_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (msg_cnt_q),
    .wdata_i (in_ch.data_byte),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  abs_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (emit_ctl),
    .sts_o   (emit_sts),
    .re_o    (ram_re),
    .raddr_o (ram_raddr),
    .rdata_i (ram_rdata),
    .out_ch  (out_ch)
  );

`ifndef SYNTHESIS
  // Input is never taken while a packet beat is on the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while a packet is being sent");

  // Output beats appear only while the sequencer waits for the readout.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> (state_q == ST_EMIT && emit_sts.busy))
    else $error("output beat outside of packet emission");

  // The wait for an ack ends only through a completed header check.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(awaiting_q) |-> $past(state_q == ST_ACK_CHK))
    else $error("awaiting flag cleared outside the ack check");

  // A packet in flight always has a running timer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> (awaiting_q && timer_q != '0))
    else $error("packet sent without a loaded timer");
`endif

endmodule
